### rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, cell encoding and port structs for the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CODE_W = 8;
  localparam int CELL_W = 16;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CELL_W-1:0] cell_t;

  localparam logic  OP_PUT       = 1'b0;
  localparam logic  OP_READ      = 1'b1;
  localparam code_t NEWLINE_CODE = 8'h0A;
  localparam code_t BLANK_CODE   = 8'h20;
  localparam code_t RESET_COLOR  = 8'h07;
  localparam cell_t RESET_CELL   = {RESET_COLOR, BLANK_CODE};

  // Screen memory write port
  typedef struct packed {
    logic  en;
    addr_t addr;
    cell_t data;
  } tcw_wr_t;

  // Screen memory read port
  typedef struct packed {
    logic  en;
    addr_t addr;
  } tcw_rd_t;

  // One result item
  typedef struct packed {
    row_t  row;
    col_t  col;
    logic  scrolled;
    cell_t data;
  } tcw_result_t;

endpackage

### rtl/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer
// 80x25 text console: put characters at a cursor, scroll, read back cells.
// ---------------------------------------------------------------------------
// Results: a put is answered from the output register; a read first passes
//   the registered screen memory read port, then the output register.
// Throughput: one put per cycle unless the skid stage is full; a read holds
//   the input until its data returns; a put that scrolls holds it while the
//   single memory port pair moves one cell per cycle (row copy, then blank fill).
// Reset: synchronous, active low; afterwards a clearing pass writes the blank
//   cell into all CELL_COUNT (2000) entries, one per cycle, before any input
//   transaction is taken. Configuration writes are taken at all times.
// ---------------------------------------------------------------------------
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: text_color
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
  input  logic        in_tuser,   // [0] operation
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [4:0] cursor_row, [11:5] cursor_column,
                                  // [12] scrolled, [28:13] read_data, rest zero
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset blank sweep
    ST_IDLE,    // take transactions
    ST_READ,    // read data returning from memory
    ST_COPY,    // move each row up by one
    ST_BLANK,   // fill bottom row with blanks
    ST_DONE     // last blank write lands, report the scroll
  } state_t;

  localparam addr_t COLS_A    = addr_t'(COLUMNS);
  localparam addr_t CELLS_A   = addr_t'(CELL_COUNT);
  localparam addr_t LAST_ADDR = addr_t'(CELL_COUNT - 1);
  localparam addr_t COPY_LAST = addr_t'(CELL_COUNT - COLUMNS - 1);
  localparam row_t  LAST_ROW  = row_t'(ROWS - 1);

  state_t      state_r,      state_nxt;
  addr_t       cp_r,         cp_nxt;
  row_t        row_r,        row_nxt;
  col_t        col_r,        col_nxt;
  code_t       color_r,      color_nxt;
  logic        rd_oor_r,     rd_oor_nxt;
  logic        wr_valid_r,   wr_valid_nxt;
  addr_t       wr_addr_r,    wr_addr_nxt;
  logic        wr_blank_r,   wr_blank_nxt;
  logic        out_valid_r,  out_valid_nxt;
  tcw_result_t out_r,        out_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  tcw_result_t skid_r,       skid_nxt;

  tcw_wr_t wr;
  tcw_rd_t rd;
  cell_t   rdata;

  logic  in_op;
  code_t in_code;
  addr_t in_idx;

  assign in_op   = in_tuser;
  assign in_code = in_tdata[7:0];
  assign in_idx  = in_tdata[18:8];

  // Accept only from idle with the skid slot free: a result may still sit in
  // the output register, the skid stage takes the next one.
  assign in_tready = (state_r == ST_IDLE) && !skid_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.data, out_r.scrolled, out_r.col, out_r.row};

  tcw_screen_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  always_comb begin
    logic              accept;
    logic              out_free;
    logic              push;
    tcw_result_t       res;
    logic [COL_W:0]    col_inc;
    logic              wrap;
    logic              is_nl;
    addr_t             pos;

    accept   = in_tvalid && in_tready;
    out_free = !out_valid_r || out_tready;
    push     = 1'b0;
    res      = '0;
    col_inc  = {1'b0, col_r} + 1'b1;
    is_nl    = (in_code == NEWLINE_CODE);
    wrap     = is_nl || (col_inc == (COL_W+1)'(COLUMNS));
    pos      = addr_t'(row_r) * COLS_A + addr_t'(col_r);

    state_nxt      = state_r;
    cp_nxt         = cp_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    color_nxt      = cfg_wr_en ? cfg_wr_data : color_r;
    rd_oor_nxt     = rd_oor_r;
    wr_valid_nxt   = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    wr_blank_nxt   = wr_blank_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;

    wr = '0;
    rd = '0;

    // Retire the pending copy or blank write from the previous cycle.
    if (wr_valid_r) begin
      wr.en   = 1'b1;
      wr.addr = wr_addr_r;
      wr.data = wr_blank_r ? {color_r, BLANK_CODE} : rdata;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = cp_r;
        wr.data = RESET_CELL;
        if (cp_r == LAST_ADDR) begin
          cp_nxt    = '0;
          state_nxt = ST_IDLE;
        end else begin
          cp_nxt = cp_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_READ) begin
            rd.en      = (in_idx < CELLS_A);
            rd.addr    = in_idx;
            rd_oor_nxt = (in_idx >= CELLS_A);
            state_nxt  = ST_READ;
          end else begin
            if (!is_nl) begin
              wr.en   = 1'b1;
              wr.addr = pos;
              wr.data = {color_r, in_code};
            end
            if (wrap) begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                // Cursor stays on the bottom row; answer after the scroll.
                cp_nxt    = '0;
                state_nxt = ST_COPY;
              end else begin
                row_nxt = row_r + 1'b1;
                push    = 1'b1;
              end
            end else begin
              col_nxt = col_inc[COL_W-1:0];
              push    = 1'b1;
            end
            res.row = row_nxt;
            res.col = col_nxt;
          end
        end
      end
      ST_READ: begin
        push      = 1'b1;
        res.row   = row_r;
        res.col   = col_r;
        res.data  = rd_oor_r ? '0 : rdata;
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        // Read one row ahead and write it back through the registered write slot.
        rd.en        = 1'b1;
        rd.addr      = cp_r + COLS_A;
        wr_valid_nxt = 1'b1;
        wr_addr_nxt  = cp_r;
        wr_blank_nxt = 1'b0;
        cp_nxt       = cp_r + 1'b1;
        if (cp_r == COPY_LAST) begin
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        wr_valid_nxt = 1'b1;
        wr_addr_nxt  = cp_r;
        wr_blank_nxt = 1'b1;
        if (cp_r == LAST_ADDR) begin
          cp_nxt    = '0;
          state_nxt = ST_DONE;
        end else begin
          cp_nxt = cp_r + 1'b1;
        end
      end
      ST_DONE: begin
        push         = 1'b1;
        res.row      = row_r;
        res.col      = col_r;
        res.scrolled = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Output register and skid stage. A push only happens with the skid
    // slot empty, so drain and push never compete for it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r && out_free) begin
      out_nxt        = skid_r;
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = 1'b0;
    end
    if (push) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cp_r         <= '0;
      row_r        <= '0;
      col_r        <= '0;
      color_r      <= RESET_COLOR;
      wr_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cp_r         <= cp_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      color_r      <= color_nxt;
      wr_valid_r   <= wr_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    rd_oor_r   <= rd_oor_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_blank_r <= wr_blank_nxt;
    out_r      <= out_nxt;
    skid_r     <= skid_nxt;
  end

  // The skid stage only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while output register is empty");

  // Cursor never leaves the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < row_t'(ROWS)) && (col_r < col_t'(COLUMNS)))
    else $error("cursor outside screen");

  // A put write at accept never collides with a queued copy or blank write.
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !wr_valid_r)
    else $error("input accepted while scroll write pending");

  // A scrolled result reports the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (out_valid_r || skid_valid_r) && (row_r == LAST_ROW)
      && (col_r == '0))
    else $error("scroll finished with wrong cursor or no result");

  // Memory reads stay inside the store.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en |-> (rd.addr < CELLS_A))
    else $error("screen read address out of range");

endmodule

### rtl/tcw_screen_ram.sv
// ---------------------------------------------------------------------------
// tcw_screen_ram
// Character-cell store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tcw_screen_ram (
  input  logic            clk,
  input  tcw_pkg::tcw_wr_t wr,
  input  tcw_pkg::tcw_rd_t rd,
  output tcw_pkg::cell_t  rdata
);
  import tcw_pkg::*;

  cell_t mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

### dv/text_console_writer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the 80x25 text console writer. Drives put and read
// transactions with random gaps, tracks the screen, cursor and color in a
// scoreboard, and checks each result word field by field.
// ---------------------------------------------------------------------------
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int MAX_GAP      = 13;
  localparam int INDEX_MAX    = 2047;  // full span of the 11-bit cell_index field

  // -------------------------------------------------------------------------
  // Scoreboard: a shadow of the screen store plus a queue of pending results
  // -------------------------------------------------------------------------
  class console_scoreboard;
    cell_t       screen [CELL_COUNT];
    row_t        row;
    col_t        col;
    code_t       color;
    tcw_result_t expected [$];
    int unsigned errors;

    function new();
      foreach (screen[i]) screen[i] = RESET_CELL;
      row    = '0;
      col    = '0;
      color  = RESET_COLOR;
      errors = 0;
    endfunction

    function void set_color(code_t value);
      color = value;
    endfunction

    // Apply one accepted input transaction and queue the result it causes.
    function void note_input(logic op, code_t code, logic [10:0] idx);
      tcw_result_t res;
      int unsigned next_col;
      res = '0;
      if (op == OP_READ) begin
        // past the end of the store reads back as zero
        if (idx < CELL_COUNT) res.data = screen[idx];
      end else begin
        if (code != NEWLINE_CODE) begin
          screen[row * COLUMNS + col] = {color, code};
          next_col = col + 1;
        end else begin
          next_col = COLUMNS;
        end
        if (next_col >= COLUMNS) begin
          next_col = 0;
          if (row == ROWS - 1) begin
            // shift every row up and blank the bottom row in the current color
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
              screen[i] = {color, BLANK_CODE};
            res.scrolled = 1'b1;
          end else begin
            row = row + 1'b1;
          end
        end
        col = col_t'(next_col);
      end
      res.row = row;
      res.col = col;
      expected.push_back(res);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      end
    endfunction

    // Check one accepted result word against the oldest pending result.
    function void check_result(logic [31:0] word);
      tcw_result_t want;
      if (expected.size() == 0) begin
        errors++;
        $error("unexpected result transaction: out_tdata 0x%0h", word);
        return;
      end
      want = expected.pop_front();
      compare("cursor_row",    want.row,      word[4:0]);
      compare("cursor_column", want.col,      word[11:5]);
      compare("scrolled",      want.scrolled, word[12]);
      compare("read_data",     want.data,     word[28:13]);
      compare("padding",       '0,            word[31:29]);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, DUT and shared state
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] char_code, [18:8] cell_index, rest zero
  logic        in_tuser;   // [0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [4:0] cursor_row, [11:5] cursor_column,
                           // [12] scrolled, [28:13] read_data, rest zero

  console_scoreboard sb;

  // Gap stretches: each side alternates runs of random gaps and runs without.
  int unsigned feed_left = 0;
  bit          feed_quiet = 1'b0;
  int unsigned sink_left = 0;
  bit          sink_quiet = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_console_writer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // Draw the idle cycles before the next transaction on one side. A new
  // stretch starts when the old one runs out; a third of them carry no gaps.
  function automatic int unsigned draw_gap(inout int unsigned left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(16, 64);
      quiet = ($urandom_range(0, 2) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // -------------------------------------------------------------------------
  // Input side. Called and returning at a falling edge; the caller either
  // sends the next item or drops in_tvalid in that same step.
  // -------------------------------------------------------------------------
  task automatic send_item(logic op, code_t code, logic [10:0] idx);
    int unsigned gap;
    gap = draw_gap(feed_left, feed_quiet);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, idx, code};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(op, code, idx);
    @(negedge clk);
  endtask

  // Hold the input until every pending result has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Change text_color while idle. A scroll reports only after its last blank
  // write, so once every result is taken nothing is left in flight.
  task automatic write_color(code_t value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_color(value);
  endtask

  // Random traffic: mostly puts with a fair share of newlines, so the cursor
  // keeps reaching the bottom row and scrolling; reads favor the rows around
  // the cursor where the latest writes and scrolls land.
  task automatic run_random_phase(int unsigned count, bit newline_burst);
    logic        op;
    code_t       code;
    logic [10:0] idx;
    int unsigned pick;
    int unsigned near_row;
    if (newline_burst) begin
      // walk to the bottom and scroll at once
      repeat (ROWS + 1) send_item(OP_PUT, NEWLINE_CODE, 11'($urandom_range(0, INDEX_MAX)));
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) == 0) drain_results();
      if ($urandom_range(0, 99) < 25) begin
        op   = OP_READ;
        code = code_t'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          idx = 11'($urandom_range(0, CELL_COUNT - 1));
        end else if (pick < 8) begin
          near_row = (sb.row > 0 && $urandom_range(0, 1) == 1) ? sb.row - 1 : sb.row;
          idx = 11'(near_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
        end else if (pick == 8) begin
          idx = 11'($urandom_range(CELL_COUNT, INDEX_MAX));
        end else begin
          idx = 11'($urandom_range(0, INDEX_MAX));
        end
      end else begin
        op   = OP_PUT;
        code = ($urandom_range(0, 11) == 0) ? NEWLINE_CODE : code_t'($urandom_range(0, 255));
        idx  = 11'($urandom_range(0, INDEX_MAX));
      end
      send_item(op, code, idx);
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: random ready gaps, check every accepted transaction
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap(sink_left, sink_quiet);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_tdata);
      @(negedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    sb          = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tuser    = OP_PUT;
    in_tdata    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset contents, out-of-range reads, and a read that carries a char_code.
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_READ, 8'h00, 11'(CELL_COUNT - 1));
    send_item(OP_READ, 8'h00, 11'(CELL_COUNT));
    send_item(OP_READ, 8'hFF, 11'h7FF);
    // Puts ignore cell_index; extremes of char_code, then a newline.
    send_item(OP_PUT, 8'h41, 11'h7FF);
    send_item(OP_PUT, 8'h00, 11'd0);
    send_item(OP_PUT, 8'hFF, 11'd0);
    send_item(OP_PUT, NEWLINE_CODE, 11'd0);
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_READ, 8'h00, 11'd1);
    send_item(OP_READ, 8'h00, 11'd2);
    send_item(OP_READ, 8'h00, 11'd3);

    write_color(8'hFF);
    send_item(OP_PUT, 8'h80, 11'd0);
    send_item(OP_PUT, 8'h7F, 11'd0);
    send_item(OP_READ, 8'h00, 11'(COLUMNS));
    send_item(OP_READ, 8'h00, 11'(COLUMNS + 1));
    send_item(OP_PUT, NEWLINE_CODE, 11'd0);

    write_color(8'h00);
    send_item(OP_PUT, BLANK_CODE, 11'd0);
    send_item(OP_READ, 8'h00, 11'(2 * COLUMNS));
    send_item(OP_PUT, NEWLINE_CODE, 11'h7FF);
    send_item(OP_READ, 8'h00, 11'd1023);

    // Random phases, each under its own color, the extremes FF and 00 among them.
    write_color(8'h1E);
    run_random_phase(275, 1'b1);
    write_color(8'hFF);
    run_random_phase(275, 1'b0);
    write_color(code_t'($urandom_range(0, 255)));
    run_random_phase(275, 1'b0);
    write_color(8'h00);
    run_random_phase(275, 1'b0);
    write_color(code_t'($urandom_range(0, 255)));
    run_random_phase(275, 1'b0);

    // Drain, then watch for stray results a while before judging.
    drain_results();
    repeat (CELL_COUNT + 16) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit: far beyond a run where every put scrolls and both sides stall.
  initial begin : watchdog
    #(64'd30_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
